### rtl/assert_macros.svh
// assertion macros shared by the glyph sector render rtl
// no dependencies; included by modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge out of reset
`define ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/tgsr_pkg.sv
// constants, types and command/status structs of the glyph sector renderer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package tgsr_pkg;

  localparam int FONT_WIDTH  = 5;
  localparam int FONT_HEIGHT = 14;
  localparam int GLYPH_COUNT = 95;
  localparam int MAX_STRING  = 64;

  localparam int STORE_DEPTH = GLYPH_COUNT * FONT_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int ROW_W       = $clog2(FONT_HEIGHT + 1);

  // divider operand widths: start position up to 1023*2040+4095
  localparam int DIV_NW = 22;
  localparam int DIV_DW = 11;
  localparam int PBIT_W = 24;
  localparam int SCR_W  = PBIT_W - 3;

  // fit count by reciprocal multiply, exact for line widths up to 2040 bits
  localparam int FIT_RECIP = (65536 + FONT_WIDTH - 1) / FONT_WIDTH;
  localparam int FIT_W     = DIV_DW + 16;

  localparam logic [7:0] CODE_SPACE = 8'h20;
  localparam logic [7:0] CODE_TILDE = 8'h7E;

  typedef enum logic [1:0] {
    ST_DRAWN   = 2'd0,
    ST_DROPPED = 2'd1,
    ST_UNSUP   = 2'd2
  } draw_status_t;

  typedef enum logic [2:0] {
    REG_GCR_MODE    = 3'd0,
    REG_BYTES_LINE  = 3'd1,
    REG_LEADER      = 3'd2,
    REG_DATA_BYTES  = 3'd3,
    REG_KEY_ENABLE  = 3'd4,
    REG_KEY_SPACING = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    DSEL_REM,
    DSEL_KEY
  } div_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_REM_GO,
    S_REM_WAIT,
    S_FIT,
    S_CHECK,
    S_ROW_INIT,
    S_ROW_RD,
    S_ROW_SPLIT,
    S_MAP,
    S_DECIDE,
    S_KEY_WAIT,
    S_EMIT,
    S_STAT
  } state_t;

  typedef struct packed {
    logic     latch;
    logic     font_wr;
    logic     load;
    logic     div_go;
    div_sel_t div_sel;
    logic     fit;
    logic     row_init;
    logic     rd;
    logic     split;
    logic     map;
    logic     emit;
    logic     emit_stat;
    logic     next_half;
    logic     next_row;
  } cmd_t;

  typedef struct packed {
    logic gcr;
    logic bpl_zero;
    logic div_busy;
    logic dropped;
    logic need_key;
    logic second;
    logic half;
    logic last_row;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic        gcr_mode;
    logic [7:0]  line_bytes;
    logic [11:0] leader_bytes;
    logic [15:0] data_bytes;
    logic        key_enable;
    logic [7:0]  key_spacing;
  } cfg_t;

  // non-printable codes draw as a space
  function automatic logic [6:0] glyph_of(input logic [7:0] code);
    logic [7:0] c;
    c = (code < CODE_SPACE || code > CODE_TILDE) ? CODE_SPACE : code;
    return 7'(c - CODE_SPACE);
  endfunction

endpackage

### rtl/text_glyph_sector_render.sv
// top level of the text glyph sector renderer: register file, sequencer, datapath
// depends on tgsr_pkg, tgsr_ctrl, tgsr_datapath
`timescale 1ns / 1ps
//
// usage
//   input channel (in_*): one word per valid/stall handshake. req_type 0 loads
//   one font row into the glyph store and gives no result; req_type 1 draws one
//   character and gives a run of byte-update words on the out_* channel, the
//   final one flagged by out_last_update.
//   a font row is written in the cycle of its accept. a draw first runs one
//   pass through the 22-bit serial divider (start modulo the line width) and
//   a reciprocal multiply for the fit count; then it starts the rows, reads
//   the glyph store for each font row, and maps and emits each touched byte,
//   running the divider for each mapped byte when key bytes are on.
//   a draw gives at most 28 words. one draw is in flight at a time;
//   in_stall is high from the accept until its last word enters the output
//   register. a dropped draw gives its status word after the divider pass and
//   fit check, a gcr draw after the load, a zero line width before any division.
//   out_stall simply holds the output register; the sequencer waits on it.
//   config goes through the apb port (registers at byte address 4*index,
//   pready always high); config must be written only while no draw is in
//   progress, which the block itself does not enforce. reset clears the
//   control state and output valid and sets the config registers to their
//   defaults; the glyph store holds garbage until font rows are written.

module text_glyph_sector_render
  import tgsr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // apb configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // input words
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_req_type,
  input  logic [7:0]            in_char_code,
  input  logic [5:0]            in_char_position,
  input  logic [9:0]            in_start_line,
  input  logic [11:0]           in_start_bit,
  input  logic [6:0]            in_glyph_number,
  input  logic [3:0]            in_glyph_row,
  input  logic [FONT_WIDTH-1:0] in_glyph_bits,
  // result words
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [15:0]           out_byte_offset,
  output logic                  out_write_valid,
  output logic [7:0]            out_update_mask,
  output logic [7:0]            out_update_bits,
  output logic [1:0]            out_draw_status,
  output logic                  out_last_update
);

  cfg_t     cfg_r;
  cmd_t     cmd;
  sts_t     sts;
  reg_idx_t reg_idx;
  logic     wr_en;

  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // register file, writes beyond the list fall through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gcr_mode     <= 1'b0;
      cfg_r.line_bytes   <= 8'd10;
      cfg_r.leader_bytes <= '0;
      cfg_r.data_bytes   <= '0;
      cfg_r.key_enable   <= 1'b0;
      cfg_r.key_spacing  <= 8'd1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_GCR_MODE:    cfg_r.gcr_mode     <= pwdata[0];
        REG_BYTES_LINE:  cfg_r.line_bytes   <= pwdata[7:0];
        REG_LEADER:      cfg_r.leader_bytes <= pwdata[11:0];
        REG_DATA_BYTES:  cfg_r.data_bytes   <= pwdata[15:0];
        REG_KEY_ENABLE:  cfg_r.key_enable   <= pwdata[0];
        REG_KEY_SPACING: cfg_r.key_spacing  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_GCR_MODE:    prdata = 32'(cfg_r.gcr_mode);
      REG_BYTES_LINE:  prdata = 32'(cfg_r.line_bytes);
      REG_LEADER:      prdata = 32'(cfg_r.leader_bytes);
      REG_DATA_BYTES:  prdata = 32'(cfg_r.data_bytes);
      REG_KEY_ENABLE:  prdata = 32'(cfg_r.key_enable);
      REG_KEY_SPACING: prdata = 32'(cfg_r.key_spacing);
      default:         prdata = '0;
    endcase
  end

  // sequencer
  tgsr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_req_type(in_req_type),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .sts        (sts)
  );

  // datapath with glyph store, divider and output register
  tgsr_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg             (cfg_r),
    .in_char_code    (in_char_code),
    .in_char_position(in_char_position),
    .in_start_line   (in_start_line),
    .in_start_bit    (in_start_bit),
    .in_glyph_number (in_glyph_number),
    .in_glyph_row    (in_glyph_row),
    .in_glyph_bits   (in_glyph_bits),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_byte_offset (out_byte_offset),
    .out_write_valid (out_write_valid),
    .out_update_mask (out_update_mask),
    .out_update_bits (out_update_bits),
    .out_draw_status (out_draw_status),
    .out_last_update (out_last_update)
  );

endmodule

### rtl/tgsr_div.sv
// restoring divider, one quotient bit per cycle
// depends on tgsr_pkg for operand widths
`timescale 1ns / 1ps

module tgsr_div
  import tgsr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic              busy,
  output logic [DIV_NW-1:0] quot,
  output logic [DIV_DW-1:0] rem
);

  localparam int CNT_W = $clog2(DIV_NW + 1);

  logic [DIV_NW-1:0] num_r, num_nxt;
  logic [DIV_DW-1:0] rem_r, rem_nxt, den_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic [DIV_DW:0]   trial;

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r, num_r[DIV_NW-1]};
    if (go) begin
      num_nxt  = num;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(DIV_NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DIV_DW'(trial - {1'b0, den_r});
        num_nxt = {num_r[DIV_NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIV_DW-1:0];
        num_nxt = {num_r[DIV_NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    if (go) begin
      den_r <= den;
    end
  end

  assign busy = busy_r;
  assign quot = num_r;
  assign rem  = rem_r;

endmodule

### rtl/tgsr_datapath.sv
// datapath: glyph store, position arithmetic, byte mapping and output word register
// depends on tgsr_pkg and tgsr_div
`timescale 1ns / 1ps

module tgsr_datapath
  import tgsr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  cfg_t                  cfg,
  input  logic [7:0]            in_char_code,
  input  logic [5:0]            in_char_position,
  input  logic [9:0]            in_start_line,
  input  logic [11:0]           in_start_bit,
  input  logic [6:0]            in_glyph_number,
  input  logic [3:0]            in_glyph_row,
  input  logic [FONT_WIDTH-1:0] in_glyph_bits,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [15:0]           out_byte_offset,
  output logic                  out_write_valid,
  output logic [7:0]            out_update_mask,
  output logic [7:0]            out_update_bits,
  output logic [1:0]            out_draw_status,
  output logic                  out_last_update
);

  logic [FONT_WIDTH-1:0] glyph_mem [STORE_DEPTH];
  logic [FONT_WIDTH-1:0] rdata_r;

  logic [7:0]        code_r;
  logic [5:0]        pos_r;
  logic [9:0]        line_r;
  logic [11:0]       bit_r;
  logic [DIV_NW-1:0] start_r;
  logic [DIV_DW-1:0] fit_r;
  logic [PBIT_W-1:0] p_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ROW_W-1:0]  row_r;
  logic [15:0]       win_mask_r, win_bits_r;
  logic              half_r;
  logic              map_ok_r;
  logic [15:0]       off_r;

  logic              out_valid_r;
  logic [15:0]       out_off_r;
  logic              out_wv_r;
  logic [7:0]        out_mask_r, out_bits_r;
  logic [1:0]        out_stat_r;
  logic              out_last_r;

  logic [DIV_DW-1:0] bpl;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic [DIV_NW-1:0] quot;
  logic [DIV_DW-1:0] rem;
  logic              div_busy;
  logic [FIT_W-1:0]  fit_prod;
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_ok;
  logic [SCR_W-1:0]  scr;
  logic [SCR_W-1:0]  off_full;
  logic [15:0]       sec;
  logic              sec_ok;
  logic [7:0]        ks;
  logic              out_free;

  assign bpl = {cfg.line_bytes, 3'b000};
  assign ks  = (cfg.key_spacing == 8'd0) ? 8'd1 : cfg.key_spacing;

  always_comb begin
    case (cmd.div_sel)
      DSEL_REM: begin
        div_num = start_r;
        div_den = bpl;
      end
      DSEL_KEY: begin
        div_num = DIV_NW'(off_r);
        div_den = DIV_DW'(ks);
      end
      default: begin
        div_num = start_r;
        div_den = bpl;
      end
    endcase
  end

  tgsr_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (cmd.div_go),
    .num  (div_num),
    .den  (div_den),
    .busy (div_busy),
    .quot (quot),
    .rem  (rem)
  );

  // characters that fit on the rest of the line
  assign fit_prod = FIT_W'(bpl - rem) * FIT_W'(FIT_RECIP);

  // glyph store: in-range font rows written on accept, each row read into a register before it is split
  assign wr_addr = ADDR_W'(ADDR_W'(in_glyph_number) * ADDR_W'(FONT_HEIGHT))
                 + ADDR_W'(in_glyph_row);
  assign wr_ok   = (32'(in_glyph_number) < GLYPH_COUNT) && (32'(in_glyph_row) < FONT_HEIGHT);

  always_ff @(posedge clk) begin
    if (cmd.font_wr && wr_ok) begin
      glyph_mem[wr_addr] <= in_glyph_bits;
    end
    if (cmd.rd) begin
      rdata_r <= glyph_mem[addr_r];
    end
  end

  // screen byte of the current half row and its place after the leader
  assign scr      = SCR_W'(p_r >> 3) + SCR_W'(half_r);
  assign off_full = scr - SCR_W'(cfg.leader_bytes);

  always_comb begin
    sec    = off_r;
    sec_ok = map_ok_r;
    if (cfg.key_enable && map_ok_r) begin
      if (rem == '0) begin
        sec_ok = 1'b0;
      end
      sec = off_r - quot[15:0] - 16'd1;
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      code_r <= in_char_code;
      pos_r  <= in_char_position;
      line_r <= in_start_line;
      bit_r  <= in_start_bit;
    end
    if (cmd.load) begin
      start_r <= DIV_NW'(DIV_NW'(line_r) * DIV_NW'(bpl)) + DIV_NW'(bit_r);
    end
    if (cmd.fit) begin
      fit_r <= fit_prod[FIT_W-1:16];
    end
    if (cmd.row_init) begin
      p_r    <= PBIT_W'(start_r) + PBIT_W'(PBIT_W'(pos_r) * PBIT_W'(FONT_WIDTH));
      addr_r <= ADDR_W'(ADDR_W'(glyph_of(code_r)) * ADDR_W'(FONT_HEIGHT));
      row_r  <= '0;
    end else if (cmd.next_row) begin
      p_r    <= p_r + PBIT_W'(bpl);
      addr_r <= addr_r + 1'b1;
      row_r  <= row_r + 1'b1;
    end
    if (cmd.split) begin
      win_bits_r <= (16'(rdata_r) << (16 - FONT_WIDTH)) >> p_r[2:0];
      win_mask_r <= (16'((1 << FONT_WIDTH) - 1) << (16 - FONT_WIDTH)) >> p_r[2:0];
      half_r     <= 1'b0;
    end else if (cmd.next_half) begin
      half_r <= 1'b1;
    end
    if (cmd.map) begin
      map_ok_r <= (scr >= SCR_W'(cfg.leader_bytes)) && (off_full < SCR_W'(cfg.data_bytes));
      off_r    <= off_full[15:0];
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.emit_stat) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.emit) begin
      out_off_r  <= sec_ok ? sec : 16'd0;
      out_wv_r   <= sec_ok;
      out_mask_r <= half_r ? win_mask_r[7:0] : win_mask_r[15:8];
      out_bits_r <= half_r ? win_bits_r[7:0] : win_bits_r[15:8];
      out_stat_r <= ST_DRAWN;
      out_last_r <= sts.last_row && (half_r || (win_mask_r[7:0] == 8'd0));
    end else if (cmd.emit_stat) begin
      out_off_r  <= '0;
      out_wv_r   <= 1'b0;
      out_mask_r <= '0;
      out_bits_r <= '0;
      out_stat_r <= cfg.gcr_mode ? ST_UNSUP : ST_DROPPED;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte_offset = out_off_r;
  assign out_write_valid = out_wv_r;
  assign out_update_mask = out_mask_r;
  assign out_update_bits = out_bits_r;
  assign out_draw_status = out_stat_r;
  assign out_last_update = out_last_r;

  assign sts.gcr      = cfg.gcr_mode;
  assign sts.bpl_zero = (cfg.line_bytes == 8'd0);
  assign sts.div_busy = div_busy;
  assign sts.dropped  = (fit_r <= DIV_DW'(pos_r)) || (32'(pos_r) >= MAX_STRING);
  assign sts.need_key = cfg.key_enable && map_ok_r;
  assign sts.second   = (win_mask_r[7:0] != 8'd0);
  assign sts.half     = half_r;
  assign sts.last_row = (row_r == ROW_W'(FONT_HEIGHT - 1));
  assign sts.out_free = out_free;

endmodule

### rtl/tgsr_ctrl.sv
// sequencer of the glyph sector renderer: accepts words and steps the datapath
// depends on tgsr_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tgsr_ctrl
  import tgsr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_req_type,
  output logic in_stall,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:      if (accept && in_req_type) state_nxt = S_LOAD;
      S_LOAD:      state_nxt = sts.gcr ? S_STAT : S_REM_GO;
      S_REM_GO:    state_nxt = sts.bpl_zero ? S_STAT : S_REM_WAIT;
      S_REM_WAIT:  if (!sts.div_busy) state_nxt = S_FIT;
      S_FIT:       state_nxt = S_CHECK;
      S_CHECK:     state_nxt = sts.dropped ? S_STAT : S_ROW_INIT;
      S_ROW_INIT:  state_nxt = S_ROW_RD;
      S_ROW_RD:    state_nxt = S_ROW_SPLIT;
      S_ROW_SPLIT: state_nxt = S_MAP;
      S_MAP:       state_nxt = S_DECIDE;
      S_DECIDE:    state_nxt = sts.need_key ? S_KEY_WAIT : S_EMIT;
      S_KEY_WAIT:  if (!sts.div_busy) state_nxt = S_EMIT;
      S_EMIT: begin
        if (sts.out_free) begin
          if (!sts.half && sts.second) begin
            state_nxt = S_MAP;
          end else if (sts.last_row) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_ROW_RD;
          end
        end
      end
      S_STAT:      if (sts.out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.div_sel = DSEL_REM;
    case (state_r)
      S_IDLE: begin
        cmd.latch   = accept && in_req_type;
        cmd.font_wr = accept && !in_req_type;
      end
      S_LOAD:      cmd.load = 1'b1;
      S_REM_GO: begin
        cmd.div_go  = !sts.bpl_zero;
        cmd.div_sel = DSEL_REM;
      end
      S_FIT:       cmd.fit = 1'b1;
      S_ROW_INIT:  cmd.row_init = 1'b1;
      S_ROW_RD:    cmd.rd = 1'b1;
      S_ROW_SPLIT: cmd.split = 1'b1;
      S_MAP:       cmd.map = 1'b1;
      S_DECIDE: begin
        cmd.div_go  = sts.need_key;
        cmd.div_sel = DSEL_KEY;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.next_half = !sts.half && sts.second;
          cmd.next_row  = !(!sts.half && sts.second) && !sts.last_row;
        end
      end
      S_STAT:      cmd.emit_stat = sts.out_free;
      default:     cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_IMPL(a_div_idle, clk, rst_n, cmd.div_go, !sts.div_busy, "divider started while busy")
  `ASSERT_IMPL(a_emit_free, clk, rst_n, cmd.emit || cmd.emit_stat, sts.out_free, "word overwrites pending result")
  `ASSERT_NEXT(a_draw_load, clk, rst_n, accept && in_req_type, state_r == S_LOAD, "draw word not loaded")

endmodule
